// ===== rtl/wpp_pkg.sv =====
// Shared types and constants for the WAV mono 8-bit PCM parser.
// No dependencies; every module of the parser imports this package.
`default_nettype none

package wpp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_SAMPLE   = 2'd0;
  localparam logic [1:0] KIND_FINISHED = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NOT_WAVE    = 2'd0;
  localparam logic [1:0] ERR_NO_FMT_DATA = 2'd1;
  localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ERR_SHORT_DATA  = 2'd3;

  // Four-character chunk ids, first byte in the top byte
  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BYTES   = 32'd16;
  localparam logic [7:0]  SAMPLE_BIAS = 8'h80;

  // One result item
  typedef struct packed {
    logic [1:0]        kind;
    logic signed [7:0] sample;
    logic [1:0]        error_code;
    logic [31:0]       sample_rate;
    logic [31:0]       length;
    logic              last;
  } res_t;

  // Up to two results produced by one input item
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/wpp_parse.sv =====
// Parser state and per-byte decode: header check, chunk walk, fmt fields, data samples.
// Depends on wpp_pkg; produces up to two result items per accepted item.
`default_nettype none

module wpp_parse
  import wpp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] file_byte,
  input  wire logic       file_end,
  output push_t           push
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_CHUNK  = 3'd1;
  localparam logic [2:0] PH_FMT    = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_PAD    = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_HALT   = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [3:0]  field_count, field_count_next;
  logic [31:0] id_shift, id_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [15:0] channel_count, channel_count_next;
  logic [15:0] sample_bits, sample_bits_next;
  logic [31:0] rate_value, rate_value_next;
  logic        format_seen, format_seen_next;
  logic        pad_pending, pad_pending_next;
  logic [31:0] data_left, data_left_next;

  logic        main_v, fin_v, end_v;
  res_t        main_res, fin_res, end_res;
  logic [31:0] byte_wide;
  logic [31:0] dec_len;
  logic        go_skip;

  assign byte_wide = {24'd0, file_byte};

  // Phase that follows a skip of the given length with the pending pad
  function automatic logic [2:0] skip_phase(input logic [31:0] len, input logic pad);
    logic [2:0] ph;
    if (len != 32'd0) ph = PH_SKIP;
    else if (pad)     ph = PH_PAD;
    else              ph = PH_CHUNK;
    return ph;
  endfunction

  function automatic res_t err_res(input logic [1:0] code);
    res_t r;
    r             = '0;
    r.kind        = KIND_ERROR;
    r.error_code  = code;
    r.last        = 1'b1;
    return r;
  endfunction

  // Decode one byte
  always_comb begin
    phase_next         = phase;
    field_count_next   = field_count;
    id_shift_next      = id_shift;
    chunk_length_next  = chunk_length;
    channel_count_next = channel_count;
    sample_bits_next   = sample_bits;
    rate_value_next    = rate_value;
    format_seen_next   = format_seen;
    pad_pending_next   = pad_pending;
    data_left_next     = data_left;
    main_v             = 1'b0;
    fin_v              = 1'b0;
    end_v              = 1'b0;
    main_res           = '0;
    fin_res            = '0;
    end_res            = '0;
    go_skip            = 1'b0;
    dec_len            = chunk_length - 32'd1;

    unique case (phase)
      PH_HEADER: begin
        id_shift_next    = {id_shift[23:0], file_byte};
        field_count_next = field_count + 4'd1;
        if ((field_count == 4'd3 && id_shift_next != ID_RIFF) ||
            (field_count == 4'd11 && id_shift_next != ID_WAVE)) begin
          main_v     = 1'b1;
          main_res   = err_res(ERR_NOT_WAVE);
          phase_next = PH_HALT;
        end else if (field_count == 4'd11) begin
          phase_next        = PH_CHUNK;
          field_count_next  = 4'd0;
          id_shift_next     = 32'd0;
          chunk_length_next = 32'd0;
        end
      end
      PH_CHUNK: begin
        if (field_count < 4'd4) begin
          id_shift_next = {id_shift[23:0], file_byte};
        end else begin
          unique case (field_count[1:0])
            2'd0: chunk_length_next = chunk_length | byte_wide;
            2'd1: chunk_length_next = chunk_length | (byte_wide << 8);
            2'd2: chunk_length_next = chunk_length | (byte_wide << 16);
            default: chunk_length_next = chunk_length | (byte_wide << 24);
          endcase
        end
        field_count_next = field_count + 4'd1;
        if (field_count == 4'd7) begin
          pad_pending_next = chunk_length_next[0];
          field_count_next = 4'd0;
          if (id_shift_next == ID_FMT) begin
            phase_next = PH_FMT;
          end else if (id_shift_next == ID_DATA) begin
            if (!format_seen || chunk_length_next == 32'd0) begin
              main_v     = 1'b1;
              main_res   = err_res(ERR_NO_FMT_DATA);
              phase_next = PH_HALT;
            end else if (channel_count != 16'd1 || sample_bits != 16'd8) begin
              main_v     = 1'b1;
              main_res   = err_res(ERR_UNSUPPORTED);
              phase_next = PH_HALT;
            end else begin
              data_left_next = chunk_length_next;
              phase_next     = PH_DATA;
            end
          end else begin
            go_skip = 1'b1;
          end
        end
      end
      PH_FMT: begin
        priority case (field_count)
          4'd2:  channel_count_next[7:0]  = file_byte;
          4'd3:  channel_count_next[15:8] = file_byte;
          4'd4:  rate_value_next[7:0]     = file_byte;
          4'd5:  rate_value_next[15:8]    = file_byte;
          4'd6:  rate_value_next[23:16]   = file_byte;
          4'd7:  rate_value_next[31:24]   = file_byte;
          4'd14: sample_bits_next[7:0]    = file_byte;
          4'd15: sample_bits_next[15:8]   = file_byte;
          default: ;
        endcase
        field_count_next = field_count + 4'd1;
        if (field_count == 4'd15) begin
          format_seen_next  = 1'b1;
          field_count_next  = 4'd0;
          chunk_length_next = (chunk_length > FMT_BYTES) ? chunk_length - FMT_BYTES : 32'd0;
          go_skip           = 1'b1;
        end
      end
      PH_SKIP: begin
        chunk_length_next = dec_len;
        if (dec_len == 32'd0) go_skip = 1'b1;
      end
      PH_PAD: begin
        pad_pending_next  = 1'b0;
        phase_next        = PH_CHUNK;
        field_count_next  = 4'd0;
        id_shift_next     = 32'd0;
        chunk_length_next = 32'd0;
      end
      PH_DATA: begin
        main_v          = 1'b1;
        main_res        = '0;
        main_res.kind   = KIND_SAMPLE;
        main_res.sample = signed'(file_byte ^ SAMPLE_BIAS);
        data_left_next  = data_left - 32'd1;
        if (data_left_next == 32'd0) begin
          fin_v               = 1'b1;
          fin_res             = '0;
          fin_res.kind        = KIND_FINISHED;
          fin_res.sample_rate = rate_value;
          fin_res.length      = chunk_length;
          fin_res.last        = 1'b1;
          phase_next          = PH_HALT;
        end
      end
      default: phase_next = PH_HALT;
    endcase

    // Move on after a skipped region: skip, pad or the next chunk header
    if (go_skip) begin
      phase_next = skip_phase(chunk_length_next, pad_pending_next);
      if (phase_next == PH_CHUNK) begin
        field_count_next  = 4'd0;
        id_shift_next     = 32'd0;
        chunk_length_next = 32'd0;
      end
    end

    // File end: report an unfinished run, then restart the parser
    if (file_end) begin
      if (phase_next != PH_HALT) begin
        end_v = 1'b1;
        if (phase_next == PH_HEADER)    end_res = err_res(ERR_NOT_WAVE);
        else if (phase_next == PH_DATA) end_res = err_res(ERR_SHORT_DATA);
        else                            end_res = err_res(ERR_NO_FMT_DATA);
      end
      phase_next         = PH_HEADER;
      field_count_next   = 4'd0;
      id_shift_next      = 32'd0;
      chunk_length_next  = 32'd0;
      channel_count_next = 16'd0;
      sample_bits_next   = 16'd0;
      rate_value_next    = 32'd0;
      format_seen_next   = 1'b0;
      pad_pending_next   = 1'b0;
      data_left_next     = 32'd0;
    end
  end

  // Pack results in order: sample or early error, then finished or end error
  always_comb begin
    push.res0  = main_v ? main_res : end_res;
    push.res1  = fin_v ? fin_res : end_res;
    push.count = {1'b0, main_v} + {1'b0, fin_v} + {1'b0, end_v};
    if (!take) push.count = 2'd0;
  end

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      field_count   <= 4'd0;
      id_shift      <= 32'd0;
      chunk_length  <= 32'd0;
      channel_count <= 16'd0;
      sample_bits   <= 16'd0;
      rate_value    <= 32'd0;
      format_seen   <= 1'b0;
      pad_pending   <= 1'b0;
      data_left     <= 32'd0;
    end else if (take) begin
      phase         <= phase_next;
      field_count   <= field_count_next;
      id_shift      <= id_shift_next;
      chunk_length  <= chunk_length_next;
      channel_count <= channel_count_next;
      sample_bits   <= sample_bits_next;
      rate_value    <= rate_value_next;
      format_seen   <= format_seen_next;
      pad_pending   <= pad_pending_next;
      data_left     <= data_left_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wpp_outq.sv =====
// Four-entry result queue: takes up to two result items per cycle, gives one
// while out_stall is low. Depends on wpp_pkg for the result record.
`default_nettype none

module wpp_outq
  import wpp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  push_t     push,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      head
);

  res_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;
  // Room for two more items is required before accepting input
  assign full      = (count > 3'd2);
  assign head      = mem[rd_ptr];

  // Write incoming results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.res0;
    if (push.count == 2'd2) mem[wr_ptr + 2'd1] <= push.res1;
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, push.count} - {2'd0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/riff_wave_pcm8_parser_unit.sv =====
// Top level of the WAV mono 8-bit PCM parser: byte decoder plus result queue.
// Depends on wpp_pkg, wpp_parse and wpp_outq.
//
// Usage: feed the file one byte per item on the input channel (in_valid,
// in_stall, file_byte, file_end). Result items leave on the output channel
// (out_valid, out_stall, kind, sample, error_code, sample_rate, length, last).
// Each data byte gives one sample item; the last data byte also gives a
// finished item with length and rate. Header or format problems give an error
// item, and a byte flagged file_end restarts the parser after its own results,
// adding an error item if the run had not ended yet.
// With an empty queue, results of a byte appear in the cycle after it is
// accepted; items already waiting in the queue go out first.
// Throughput: one byte per cycle while in_stall is low; the decode is a single
// registered pass and the four-entry result queue absorbs the two-result bytes.
// in_stall rises when the queue holds three or four items, so behind a
// stalled receiver bytes keep entering until that many result items wait.
// Reset: rst (synchronous) returns the parser to expecting the RIFF header
// and empties the result queue.
`default_nettype none

module riff_wave_pcm8_parser_unit
  import wpp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  file_byte,
  input  wire logic        file_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic signed [7:0] sample,
  output logic [1:0]       error_code,
  output logic [31:0]      sample_rate,
  output logic [31:0]      length,
  output logic             last
);

  push_t push;
  res_t  head;
  logic  full;
  logic  take;

  assign in_stall = full;
  assign take     = in_valid && !full;

  wpp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .file_byte (file_byte),
    .file_end  (file_end),
    .push      (push)
  );

  wpp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Drive result fields from the queue head
  assign kind        = head.kind;
  assign sample      = head.sample;
  assign error_code  = head.error_code;
  assign sample_rate = head.sample_rate;
  assign length      = head.length;
  assign last        = head.last;

`ifndef SYNTHESIS
  a_sample_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_SAMPLE) |-> !last)
    else $error("sample item marked last");

  a_finished_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_FINISHED) |-> (last && error_code == ERR_NOT_WAVE
      && sample == 8'sd0))
    else $error("finished item carries stray fields");

  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result queue");
`endif

endmodule

`default_nettype wire
